@@ rtl/pmpc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmpc_pkg
// Shared widths, constants, register indexes and stage payload types of the
// PID motor position controller.
// ----------------------------------------------------------------------------
package pmpc_pkg;

    localparam int TARGET_W   = 8;
    localparam int ENC_W      = 16;
    localparam int SCALE_W    = 8;
    localparam int GAIN_W     = 16;
    localparam int RAW_PROD_W = SCALE_W + ENC_W;
    localparam int MEAS_W     = 15;
    localparam int ERR_W      = 17;
    localparam int INTEG_W    = 16;
    localparam int SUM_W      = 18;
    localparam int DERR_W     = 18;
    localparam int PROD_W     = 35;
    localparam int ACC_W      = 37;
    localparam int FRAC_W     = 8;
    localparam int DRIVE_W    = 9;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 16;

    localparam int DRIVE_LIMIT = 255;

    localparam logic [MEAS_W-1:0]            MEAS_MAX   = '1;
    localparam logic signed [ERR_W-1:0]      ERR_WINDOW = 17'sd20;
    localparam logic signed [SUM_W-1:0]      INTEG_HI   = 18'sd32767;
    localparam logic signed [SUM_W-1:0]      INTEG_LO   = -18'sd32768;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_MEASURE_SCALE = 2'd0,
        CFG_PROP_GAIN     = 2'd1,
        CFG_INTEG_GAIN    = 2'd2,
        CFG_DERIV_GAIN    = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [SCALE_W-1:0] measure_scale;
        logic [GAIN_W-1:0]  prop_gain;
        logic [GAIN_W-1:0]  integ_gain;
        logic [GAIN_W-1:0]  deriv_gain;
    } cfg_t;

    typedef struct packed {
        logic                tick;
        logic [TARGET_W-1:0] target;
        logic [ENC_W-1:0]    encoder_count;
    } in_item_t;

    typedef struct packed {
        logic                tick;
        logic [TARGET_W-1:0] target;
        logic [MEAS_W-1:0]   measured;
    } meas_t;

    typedef struct packed {
        logic                      tick;
        logic signed [ERR_W-1:0]   err;
        logic signed [INTEG_W-1:0] integ;
        logic signed [DERR_W-1:0]  derr;
    } err_t;

    typedef struct packed {
        logic                     tick;
        logic signed [PROD_W-1:0] p_term;
        logic signed [PROD_W-1:0] i_term;
        logic signed [PROD_W-1:0] d_term;
    } prod_t;

    typedef struct packed {
        logic                    tick;
        logic signed [ACC_W-1:0] acc;
    } acc_t;

endpackage

@@ rtl/pmpc_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmpc_cfg_regs
// Configuration register file: scale factor and the three Q8.8 gains.
// ----------------------------------------------------------------------------
module pmpc_cfg_regs (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [pmpc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [pmpc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output pmpc_pkg::cfg_t             cfg
);
    import pmpc_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.measure_scale <= SCALE_W'(1);
            cfg_reg.prop_gain     <= '0;
            cfg_reg.integ_gain    <= '0;
            cfg_reg.deriv_gain    <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_MEASURE_SCALE: cfg_reg.measure_scale <= cfg_wdata[SCALE_W-1:0];
                CFG_PROP_GAIN:     cfg_reg.prop_gain     <= cfg_wdata[GAIN_W-1:0];
                CFG_INTEG_GAIN:    cfg_reg.integ_gain    <= cfg_wdata[GAIN_W-1:0];
                CFG_DERIV_GAIN:    cfg_reg.deriv_gain    <= cfg_wdata[GAIN_W-1:0];
                default:           cfg_reg.measure_scale <= cfg_reg.measure_scale;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/pmpc_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmpc_front
// Input register, encoder scaling with saturation, then error forming and the
// integral / previous-error state update.
// ----------------------------------------------------------------------------
module pmpc_front (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic [pmpc_pkg::SCALE_W-1:0] measure_scale,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  pmpc_pkg::in_item_t      in_item,
    output logic                    err_valid,
    input  logic                    err_ready,
    output pmpc_pkg::err_t          err_item
);
    import pmpc_pkg::*;

    logic     a_valid_reg;
    in_item_t a_reg;
    logic     b_valid_reg;
    meas_t    b_reg;
    logic     c_valid_reg;
    err_t     c_reg;

    logic signed [INTEG_W-1:0] integ_reg;
    logic signed [INTEG_W-1:0] integ_next;
    logic signed [ERR_W-1:0]   last_err_reg;

    logic a_en, b_en, c_en;

    logic [RAW_PROD_W-1:0]     raw_prod;
    meas_t                     b_next;

    logic signed [ERR_W-1:0]   err_c;
    logic signed [INTEG_W-1:0] integ_base;
    logic signed [SUM_W-1:0]   sum_c;
    err_t                      c_next;

    // stall chain: a stage loads when empty or when its contents move on
    assign c_en     = !c_valid_reg || err_ready;
    assign b_en     = !b_valid_reg || c_en;
    assign a_en     = !a_valid_reg || b_en;
    assign in_ready = a_en;

    // scaling
    always_comb begin
        raw_prod        = measure_scale * a_reg.encoder_count;
        b_next.tick     = a_reg.tick;
        b_next.target   = a_reg.target;
        if (raw_prod > RAW_PROD_W'(MEAS_MAX)) begin
            b_next.measured = MEAS_MAX;
        end else begin
            b_next.measured = raw_prod[MEAS_W-1:0];
        end
    end

    // error and integral
    always_comb begin
        err_c = $signed({{(ERR_W-TARGET_W){1'b0}}, b_reg.target})
              - $signed({{(ERR_W-MEAS_W){1'b0}}, b_reg.measured});
        // leaving the window restarts the integral
        if ((err_c > ERR_WINDOW) || (err_c < -ERR_WINDOW)) begin
            integ_base = '0;
        end else begin
            integ_base = integ_reg;
        end
        sum_c = $signed({{(SUM_W-INTEG_W){integ_base[INTEG_W-1]}}, integ_base})
              + $signed({{(SUM_W-ERR_W){err_c[ERR_W-1]}}, err_c});
        if (sum_c > INTEG_HI) begin
            integ_next = INTEG_HI[INTEG_W-1:0];
        end else if (sum_c < INTEG_LO) begin
            integ_next = INTEG_LO[INTEG_W-1:0];
        end else begin
            integ_next = sum_c[INTEG_W-1:0];
        end
        c_next.tick  = b_reg.tick;
        c_next.err   = err_c;
        c_next.integ = integ_next;
        c_next.derr  = $signed({{(DERR_W-ERR_W){err_c[ERR_W-1]}}, err_c})
                     - $signed({{(DERR_W-ERR_W){last_err_reg[ERR_W-1]}}, last_err_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg  <= 1'b0;
            b_valid_reg  <= 1'b0;
            c_valid_reg  <= 1'b0;
            integ_reg    <= '0;
            last_err_reg <= '0;
        end else begin
            if (a_en) begin
                a_valid_reg <= in_valid;
            end
            if (b_en) begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_en) begin
                c_valid_reg <= b_valid_reg;
                if (b_valid_reg && b_reg.tick) begin
                    integ_reg    <= integ_next;
                    last_err_reg <= err_c;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_en) begin
            a_reg <= in_item;
        end
        if (b_en) begin
            b_reg <= b_next;
        end
        if (c_en) begin
            c_reg <= c_next;
        end
    end

    assign err_valid = c_valid_reg;
    assign err_item  = c_reg;

endmodule

@@ rtl/pmpc_gain.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmpc_gain
// P, I and D products in one registered stage, their sum in the next.
// ----------------------------------------------------------------------------
module pmpc_gain (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  pmpc_pkg::cfg_t       cfg,
    input  logic                 err_valid,
    output logic                 err_ready,
    input  pmpc_pkg::err_t       err_item,
    output logic                 acc_valid,
    input  logic                 acc_ready,
    output pmpc_pkg::acc_t       acc_item
);
    import pmpc_pkg::*;

    localparam int P_W = GAIN_W + 1 + ERR_W;
    localparam int I_W = GAIN_W + 1 + INTEG_W;
    localparam int D_W = GAIN_W + 1 + DERR_W;

    logic  p_valid_reg;
    prod_t p_reg;
    logic  q_valid_reg;
    acc_t  q_reg;
    logic  p_en, q_en;

    logic signed [P_W-1:0] p_c;
    logic signed [I_W-1:0] i_c;
    logic signed [D_W-1:0] d_c;
    prod_t                 p_next;
    acc_t                  q_next;

    assign q_en      = !q_valid_reg || acc_ready;
    assign p_en      = !p_valid_reg || q_en;
    assign err_ready = p_en;

    // gains are unsigned, so a zero sign bit goes on top
    always_comb begin
        p_c = $signed({1'b0, cfg.prop_gain})  * err_item.err;
        i_c = $signed({1'b0, cfg.integ_gain}) * err_item.integ;
        d_c = $signed({1'b0, cfg.deriv_gain}) * err_item.derr;
        p_next.tick   = err_item.tick;
        p_next.p_term = $signed({{(PROD_W-P_W){p_c[P_W-1]}}, p_c});
        p_next.i_term = $signed({{(PROD_W-I_W){i_c[I_W-1]}}, i_c});
        p_next.d_term = d_c;
    end

    always_comb begin
        q_next.tick = p_reg.tick;
        q_next.acc  = $signed({{(ACC_W-PROD_W){p_reg.p_term[PROD_W-1]}}, p_reg.p_term})
                    + $signed({{(ACC_W-PROD_W){p_reg.i_term[PROD_W-1]}}, p_reg.i_term})
                    + $signed({{(ACC_W-PROD_W){p_reg.d_term[PROD_W-1]}}, p_reg.d_term});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
            q_valid_reg <= 1'b0;
        end else begin
            if (p_en) begin
                p_valid_reg <= err_valid;
            end
            if (q_en) begin
                q_valid_reg <= p_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (p_en) begin
            p_reg <= p_next;
        end
        if (q_en) begin
            q_reg <= q_next;
        end
    end

    assign acc_valid = q_valid_reg;
    assign acc_item  = q_reg;

endmodule

@@ rtl/pmpc_out.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmpc_out
// Truncation toward zero, clamp to the drive limit, hold of the last drive
// for non-tick items, and the result register.
// ----------------------------------------------------------------------------
module pmpc_out (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 acc_valid,
    output logic                 acc_ready,
    input  pmpc_pkg::acc_t       acc_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [pmpc_pkg::DRIVE_W-1:0] out_drive
);
    import pmpc_pkg::*;

    localparam int Q_W = ACC_W - FRAC_W;
    localparam logic signed [Q_W-1:0]     Q_HI     = Q_W'(DRIVE_LIMIT);
    localparam logic signed [Q_W-1:0]     Q_LO     = -Q_HI;
    localparam logic signed [DRIVE_W-1:0] DRIVE_HI = DRIVE_W'(DRIVE_LIMIT);
    localparam logic signed [DRIVE_W-1:0] DRIVE_LO = -DRIVE_HI;

    logic                      out_valid_reg;
    logic signed [DRIVE_W-1:0] drive_reg;
    logic signed [DRIVE_W-1:0] drive_next;
    logic signed [DRIVE_W-1:0] last_drive_reg;
    logic                      out_en;

    logic signed [ACC_W-1:0]   biased;
    logic signed [Q_W-1:0]     q_c;
    logic signed [DRIVE_W-1:0] clamped;

    assign out_en    = !out_valid_reg || out_ready;
    assign acc_ready = out_en;

    always_comb begin
        // negative values get 255 added first so the shift rounds toward zero
        biased = acc_item.acc
               + $signed({{(ACC_W-FRAC_W){1'b0}}, {FRAC_W{acc_item.acc[ACC_W-1]}}});
        q_c    = biased[ACC_W-1:FRAC_W];
        priority if (q_c >= Q_HI) begin
            clamped = DRIVE_HI;
        end else if (q_c <= Q_LO) begin
            clamped = DRIVE_LO;
        end else begin
            clamped = q_c[DRIVE_W-1:0];
        end
        drive_next = acc_item.tick ? clamped : last_drive_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            last_drive_reg <= '0;
        end else if (out_en) begin
            out_valid_reg <= acc_valid;
            if (acc_valid && acc_item.tick) begin
                last_drive_reg <= clamped;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_en) begin
            drive_reg <= drive_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_drive = drive_reg;

endmodule

@@ rtl/pid_motor_position_controller.sv @@
`timescale 1ns / 1ps
// Pipeline: from the s_ transfer to m_tvalid through the input, scale, error,
//   product and sum stages, then the result register.
// Throughput: one item per cycle; set by the encoder-scale and gain multipliers,
//   each followed by a register. Stalls on m_tready back up through every stage.
// Reset: aresetn, synchronous active low; empties the pipeline, clears integral,
//   previous error and last drive, and loads measure_scale = 1, all gains = 0.
// ----------------------------------------------------------------------------
// pid_motor_position_controller
// Discrete PID position controller with Q8.8 gains and a clamped drive output.
// ----------------------------------------------------------------------------
module pid_motor_position_controller (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              cfg_wr_en,
    input  logic [pmpc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [pmpc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [pmpc_pkg::S_TDATA_W-1:0]    s_tdata,  // [7:0] target, [23:8] encoder_count
    input  logic                              s_tuser,  // [0] sample_tick
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [pmpc_pkg::M_TDATA_W-1:0]    m_tdata   // [8:0] drive (signed), [15:9] zero
);
    import pmpc_pkg::*;

    cfg_t                      cfg;
    in_item_t                  in_item;
    logic                      err_valid, err_ready;
    err_t                      err_item;
    logic                      acc_valid, acc_ready;
    acc_t                      acc_item;
    logic signed [DRIVE_W-1:0] drive;

    assign in_item.tick          = s_tuser;
    assign in_item.target        = s_tdata[TARGET_W-1:0];
    assign in_item.encoder_count = s_tdata[TARGET_W+ENC_W-1:TARGET_W];

    pmpc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    pmpc_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .measure_scale (cfg.measure_scale),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_item       (in_item),
        .err_valid     (err_valid),
        .err_ready     (err_ready),
        .err_item      (err_item)
    );

    pmpc_gain u_gain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .err_valid (err_valid),
        .err_ready (err_ready),
        .err_item  (err_item),
        .acc_valid (acc_valid),
        .acc_ready (acc_ready),
        .acc_item  (acc_item)
    );

    pmpc_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .acc_valid (acc_valid),
        .acc_ready (acc_ready),
        .acc_item  (acc_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_drive (drive)
    );

    assign m_tdata = {{(M_TDATA_W-DRIVE_W){1'b0}}, drive};

endmodule

@@ rtl/pmpc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmpc_checker
// Port-level checks of the PID controller, bound to the top level.
// ----------------------------------------------------------------------------
module pmpc_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [pmpc_pkg::M_TDATA_W-1:0]  m_tdata
);
    import pmpc_pkg::*;

    // a reset cycle leaves no result pending
    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // an empty pipeline always takes input
    a_ready_after_reset: assert property (@(posedge aclk)
        ($past(!aresetn) && aresetn) |-> s_tready)
        else $error("input not ready after reset release");

    // drive stays in -255..255 and the pad bits stay zero
    a_drive_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[DRIVE_W-1:0] != {1'b1, {(DRIVE_W-1){1'b0}}})
                      && (m_tdata[M_TDATA_W-1:DRIVE_W] == '0)))
        else $error("drive out of range or pad bits set");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind pid_motor_position_controller pmpc_checker u_pmpc_checker (.*);
